[sv/triad_pkg.sv]
// Shared types and constants for the TRIAD attitude block.
package triad_pkg;

  localparam int IN_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int OUT_W         = 16;
  localparam int NORM_HIGH     = 30;
  localparam int QDEPTH        = 4;

  typedef struct packed {
    logic signed [IN_WIDTH_DEF-1:0] mag_ref_x;
    logic signed [IN_WIDTH_DEF-1:0] mag_ref_y;
    logic signed [IN_WIDTH_DEF-1:0] mag_ref_z;
    logic signed [IN_WIDTH_DEF-1:0] mag_obs_x;
    logic signed [IN_WIDTH_DEF-1:0] mag_obs_y;
    logic signed [IN_WIDTH_DEF-1:0] mag_obs_z;
    logic signed [IN_WIDTH_DEF-1:0] sun_ref_x;
    logic signed [IN_WIDTH_DEF-1:0] sun_ref_y;
    logic signed [IN_WIDTH_DEF-1:0] sun_ref_z;
    logic signed [IN_WIDTH_DEF-1:0] sun_obs_x;
    logic signed [IN_WIDTH_DEF-1:0] sun_obs_y;
    logic signed [IN_WIDTH_DEF-1:0] sun_obs_z;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] rot_00;
    logic signed [OUT_W-1:0] rot_01;
    logic signed [OUT_W-1:0] rot_02;
    logic signed [OUT_W-1:0] rot_10;
    logic signed [OUT_W-1:0] rot_11;
    logic signed [OUT_W-1:0] rot_12;
    logic signed [OUT_W-1:0] rot_20;
    logic signed [OUT_W-1:0] rot_21;
    logic signed [OUT_W-1:0] rot_22;
    logic                    degenerate;
  } out_item_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic signed [2:0][IN_WIDTH_DEF-1:0] mr;
    logic signed [2:0][IN_WIDTH_DEF-1:0] mo;
    logic signed [2:0][2*IN_WIDTH_DEF:0] cr;
    logic signed [2:0][2*IN_WIDTH_DEF:0] co;
    logic                                degenerate;
  } work_t;

endpackage

[sv/triad_front.sv]
// Front part: accepts vector sets, forms both cross products, flags degenerate sets.
module triad_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  triad_pkg::in_item_t in_data,
  output logic               w_valid,
  input  logic               w_ready,
  output triad_pkg::work_t   w_data
);

  localparam int IN_WIDTH = triad_pkg::IN_WIDTH_DEF;
  localparam int CW = 2 * IN_WIDTH + 1;

  // Stage 1 holds the products, stage 2 the differences.
  logic                           s1_valid;
  logic signed [2*IN_WIDTH-1:0]   pr [6];
  logic signed [2*IN_WIDTH-1:0]   po [6];
  logic signed [2:0][IN_WIDTH-1:0]   s1_mr;
  logic signed [2:0][IN_WIDTH-1:0]   s1_mo;
  logic                           s2_valid;
  triad_pkg::work_t               s2;
  logic                           adv1;
  logic                           adv2;
  logic signed [2:0][CW-1:0]      cr;
  logic signed [2:0][CW-1:0]      co;

  assign adv2     = !s2_valid || w_ready;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= in_valid;
      if (adv2) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_mr <= {in_data.mag_ref_z, in_data.mag_ref_y, in_data.mag_ref_x};
      s1_mo <= {in_data.mag_obs_z, in_data.mag_obs_y, in_data.mag_obs_x};
      pr[0] <= in_data.mag_ref_y * in_data.sun_ref_z;
      pr[1] <= in_data.mag_ref_z * in_data.sun_ref_y;
      pr[2] <= in_data.mag_ref_z * in_data.sun_ref_x;
      pr[3] <= in_data.mag_ref_x * in_data.sun_ref_z;
      pr[4] <= in_data.mag_ref_x * in_data.sun_ref_y;
      pr[5] <= in_data.mag_ref_y * in_data.sun_ref_x;
      po[0] <= in_data.mag_obs_y * in_data.sun_obs_z;
      po[1] <= in_data.mag_obs_z * in_data.sun_obs_y;
      po[2] <= in_data.mag_obs_z * in_data.sun_obs_x;
      po[3] <= in_data.mag_obs_x * in_data.sun_obs_z;
      po[4] <= in_data.mag_obs_x * in_data.sun_obs_y;
      po[5] <= in_data.mag_obs_y * in_data.sun_obs_x;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = CW'(pr[2*i]) - CW'(pr[2*i+1]);
      co[i] = CW'(po[2*i]) - CW'(po[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2.mr <= s1_mr;
      s2.mo <= s1_mo;
      s2.cr <= cr;
      s2.co <= co;
      s2.degenerate <= (s1_mr == '0) || (s1_mo == '0) || (cr == '0) || (co == '0);
    end
  end

  assign w_valid = s2_valid;
  assign w_data  = s2;

endmodule

[sv/triad_queue.sv]
// Short FIFO between the front and back parts.
module triad_queue #(
  parameter int DEPTH = triad_pkg::QDEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  triad_pkg::work_t wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output triad_pkg::work_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  triad_pkg::work_t mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = count != (AW+1)'(DEPTH);
  assign rd_valid = count != '0;
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (do_rd) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wr_data;
  end

endmodule

[sv/triad_back.sv]
// Back part: normalizes the triad vectors and builds the rotation matrix in a pipeline.
module triad_back #(
  parameter int FRAC_BITS = triad_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 w_valid,
  output logic                 w_ready,
  input  triad_pkg::work_t     w_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output triad_pkg::out_item_t out_data
);

  localparam int IN_WIDTH = triad_pkg::IN_WIDTH_DEF;
  localparam int CW   = 2 * IN_WIDTH + 1;
  localparam int NH   = triad_pkg::NORM_HIGH;
  localparam int MW   = NH;                 // normalized magnitude width
  localparam int SW   = 2 * NH + 2;         // sum of squares width
  localparam int RW   = NH + 1;             // root width
  localparam int QW   = FRAC_BITS + 2;      // unit component magnitude width
  localparam int NUMW = MW + FRAC_BITS + 1;
  localparam int TW   = FRAC_BITS + 3;      // signed unit component width
  localparam int SQ_ST = RW;                // one root bit per stage
  localparam int DV_ST = QW;                // one quotient bit per stage
  // Stages behind stage A: B, root, division, t3 products, triads, matrix products, output register.
  localparam int NST  = 1 + SQ_ST + DV_ST + 4;
  localparam int OW   = triad_pkg::OUT_W;
  localparam int PW   = 2 * TW;
  localparam int LW   = $clog2(CW + NH + 1);

  // The whole pipeline holds while a finished matrix waits in the output register.
  logic            adv;
  logic            take;
  logic [NST-1:0]  vpipe;

  assign adv     = !out_valid || out_ready;
  assign w_ready = adv;
  assign take    = w_valid && adv;

  // Stage A: magnitudes and normalizing shifts.
  logic [3:0][2:0][CW-2:0] a_mag;
  logic [3:0][2:0]         a_neg;
  logic [3:0][LW-1:0]      a_lead;
  logic                    a_deg;

  function automatic logic [LW-1:0] lead_pos(input logic [CW-2:0] x);
    logic [LW-1:0] p;
    p = '0;
    for (int i = 0; i < CW - 1; i++) if (x[i]) p = LW'(i);
    return p;
  endfunction

  always_ff @(posedge clk) begin
    logic signed [CW-1:0] v;
    logic [CW-2:0] mx;
    if (take) begin
      a_deg <= w_data.degenerate;
      for (int q = 0; q < 4; q++) begin
        mx = '0;
        for (int i = 0; i < 3; i++) begin
          unique case (q)
            0: v = CW'(signed'(w_data.mr[i]));
            1: v = w_data.cr[i][CW-1:0];
            2: v = CW'(signed'(w_data.mo[i]));
            default: v = w_data.co[i][CW-1:0];
          endcase
          a_neg[q][i] <= v[CW-1];
          a_mag[q][i] <= v[CW-1] ? (CW-1)'(-v) : v[CW-2:0];
          mx = mx | (v[CW-1] ? (CW-1)'(-v) : v[CW-2:0]);
        end
        a_lead[q] <= lead_pos(mx);
      end
    end
  end

  // Stage B: shifted magnitudes and sum of squares.
  logic [3:0][2:0][MW-1:0] b_m;
  logic [3:0][2:0]         b_neg;
  logic [3:0][SW-1:0]      b_sum;
  logic                    b_deg;

  always_ff @(posedge clk) begin
    logic [MW-1:0] m;
    logic [SW-1:0] s;
    if (adv && vpipe[0]) begin
      b_deg <= a_deg;
      b_neg <= a_neg;
      for (int q = 0; q < 4; q++) begin
        s = '0;
        for (int i = 0; i < 3; i++) begin
          if (a_lead[q] >= LW'(NH - 1))
            m = MW'(a_mag[q][i] >> (a_lead[q] - LW'(NH - 1)));
          else
            m = MW'({{NH{1'b0}}, a_mag[q][i]} << (LW'(NH - 1) - a_lead[q]));
          b_m[q][i] <= m;
          s = s + SW'(m) * SW'(m);
        end
        b_sum[q] <= s;
      end
    end
  end

  // Square root, one result bit per stage.
  logic [3:0][2:0][MW-1:0] sq_m   [SQ_ST+1];
  logic [3:0][2:0]         sq_neg [SQ_ST+1];
  logic [3:0][SW-1:0]      sq_rem [SQ_ST+1];
  logic [3:0][RW-1:0]      sq_res [SQ_ST+1];
  logic                    sq_deg [SQ_ST+1];

  always_comb begin
    sq_m[0]   = b_m;
    sq_neg[0] = b_neg;
    sq_rem[0] = b_sum;
    sq_res[0] = '0;
    sq_deg[0] = b_deg;
  end

  for (genvar g = 0; g < SQ_ST; g++) begin : g_sqrt
    localparam int BIT = RW - 1 - g;
    always_ff @(posedge clk) begin
      logic [SW+1:0] trial;
      if (adv && vpipe[1 + g]) begin
        sq_m[g+1]   <= sq_m[g];
        sq_neg[g+1] <= sq_neg[g];
        sq_deg[g+1] <= sq_deg[g];
        for (int q = 0; q < 4; q++) begin
          trial = ((SW+2)'(sq_res[g][q]) << (BIT + 1)) + ((SW+2)'(1) << (2 * BIT));
          if ((SW+2)'(sq_rem[g][q]) >= trial) begin
            sq_rem[g+1][q] <= SW'((SW+2)'(sq_rem[g][q]) - trial);
            sq_res[g+1][q] <= sq_res[g][q] | (RW'(1) << BIT);
          end else begin
            sq_rem[g+1][q] <= sq_rem[g][q];
            sq_res[g+1][q] <= sq_res[g][q];
          end
        end
      end
    end
  end

  // Division: (m << FRAC_BITS) + n/2 over n, one quotient bit per stage.
  logic [3:0][2:0][NUMW-1:0] dv_rem [DV_ST+1];
  logic [3:0][2:0][QW-1:0]   dv_q   [DV_ST+1];
  logic [3:0][RW-1:0]        dv_n   [DV_ST+1];
  logic [3:0][2:0]           dv_neg [DV_ST+1];
  logic                      dv_deg [DV_ST+1];

  always_comb begin
    dv_n[0]   = sq_res[SQ_ST];
    dv_neg[0] = sq_neg[SQ_ST];
    dv_deg[0] = sq_deg[SQ_ST];
    dv_q[0]   = '0;
    for (int q = 0; q < 4; q++)
      for (int i = 0; i < 3; i++)
        dv_rem[0][q][i] = (NUMW'(sq_m[SQ_ST][q][i]) << FRAC_BITS)
                          + NUMW'(sq_res[SQ_ST][q] >> 1);
  end

  for (genvar g = 0; g < DV_ST; g++) begin : g_div
    localparam int BIT = QW - 1 - g;
    always_ff @(posedge clk) begin
      logic [NUMW+QW-1:0] d;
      if (adv && vpipe[1 + SQ_ST + g]) begin
        dv_n[g+1]   <= dv_n[g];
        dv_neg[g+1] <= dv_neg[g];
        dv_deg[g+1] <= dv_deg[g];
        for (int q = 0; q < 4; q++)
          for (int i = 0; i < 3; i++) begin
            d = (NUMW+QW)'(dv_n[g][q]) << BIT;
            if ((NUMW+QW)'(dv_rem[g][q][i]) >= d) begin
              dv_rem[g+1][q][i] <= NUMW'((NUMW+QW)'(dv_rem[g][q][i]) - d);
              dv_q[g+1][q][i]   <= dv_q[g][q][i] | (QW'(1) << BIT);
            end else begin
              dv_rem[g+1][q][i] <= dv_rem[g][q][i];
              dv_q[g+1][q][i]   <= dv_q[g][q][i];
            end
          end
      end
    end
  end

  function automatic logic signed [TW-1:0] rnd(input logic signed [PW:0] v);
    logic [PW:0] m;
    m = v[PW] ? -v : v;
    m = (m + (PW+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[PW] ? -TW'(m) : TW'(m);
  endfunction

  // Signed unit vectors, then products for t3.
  localparam int ST_T = 1 + SQ_ST + DV_ST;
  logic signed [TW-1:0] u  [4][3];
  logic signed [PW-1:0] tp [2][6];
  logic signed [TW-1:0] u2 [4][3];
  logic                 t_deg;
  logic                 t2_deg;

  always_comb begin
    for (int q = 0; q < 4; q++)
      for (int i = 0; i < 3; i++)
        u[q][i] = dv_neg[DV_ST][q][i] ? -TW'(dv_q[DV_ST][q][i]) : TW'(dv_q[DV_ST][q][i]);
  end

  always_ff @(posedge clk) begin
    if (adv && vpipe[ST_T]) begin
      u2    <= u;
      t_deg <= dv_deg[DV_ST];
      for (int f = 0; f < 2; f++) begin
        tp[f][0] <= u[2*f][1] * u[2*f+1][2];
        tp[f][1] <= u[2*f][2] * u[2*f+1][1];
        tp[f][2] <= u[2*f][2] * u[2*f+1][0];
        tp[f][3] <= u[2*f][0] * u[2*f+1][2];
        tp[f][4] <= u[2*f][0] * u[2*f+1][1];
        tp[f][5] <= u[2*f][1] * u[2*f+1][0];
      end
    end
  end

  // Triads: t[frame][k][comp].
  logic signed [TW-1:0] tri3 [2][3][3];
  logic signed [PW-1:0] mp   [3][3][3];

  always_ff @(posedge clk) begin
    logic signed [TW-1:0] t3;
    if (adv && vpipe[ST_T + 1]) begin
      t2_deg <= t_deg;
      for (int f = 0; f < 2; f++) begin
        for (int i = 0; i < 3; i++) begin
          tri3[f][0][i] <= u2[2*f][i];
          tri3[f][1][i] <= u2[2*f+1][i];
          t3 = rnd((PW+1)'(tp[f][2*i]) - (PW+1)'(tp[f][2*i+1]));
          tri3[f][2][i] <= t3;
        end
      end
    end
  end

  logic mp_deg;
  always_ff @(posedge clk) begin
    if (adv && vpipe[ST_T + 2]) begin
      mp_deg <= t2_deg;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          for (int k = 0; k < 3; k++)
            mp[r][c][k] <= tri3[1][k][r] * tri3[0][k][c];
    end
  end

  // Final stage: sum, round, clamp, into the output register.
  triad_pkg::out_item_t res;
  always_comb begin
    logic signed [PW+1:0] acc;
    logic signed [TW-1:0] v;
    logic signed [OW-1:0] e [9];
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        acc = (PW+2)'(mp[r][c][0]) + (PW+2)'(mp[r][c][1]) + (PW+2)'(mp[r][c][2]);
        v = rnd(acc[PW:0]);
        if (v > TW'(1 << FRAC_BITS)) v = TW'(1 << FRAC_BITS);
        if (v < -TW'(1 << FRAC_BITS)) v = -TW'(1 << FRAC_BITS);
        e[r*3+c] = mp_deg ? '0 : OW'(v);
      end
    res = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], mp_deg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vpipe     <= {vpipe[NST-2:0], take};
      out_valid <= vpipe[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vpipe[NST-1]) out_data <= res;
  end

endmodule

[sv/triad_attitude_matrix.sv]
// Top level of the TRIAD attitude matrix block.
//
//   channel | signals                     | direction
//   --------+-----------------------------+----------
//   input   | in_valid, in_ready, in_data | into block, one vector set per beat
//   output  | out_valid, out_ready, out_data | out of block, one matrix per beat
//
// One beat is accepted per cycle while the output side keeps up. An input beat passes through
// two front stages and the queue, then 2 + (NORM_HIGH+1) + (FRAC_BITS+2) + 4 = 53 back stages,
// the root and the quotient each taking one bit per stage, the last stage the output register.
// Reset (rst, synchronous) clears all valid state; payload registers are not reset.
// Either side may stall on its own: a waiting output beat freezes the back pipeline,
// and the queue and the front's two stages absorb input beats meanwhile.
module triad_attitude_matrix #(
  parameter int FRAC_BITS = triad_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  triad_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output triad_pkg::out_item_t out_data
);

  // Front to queue.
  logic             f_valid;
  logic             f_ready;
  triad_pkg::work_t f_data;
  // Queue to back.
  logic             q_valid;
  logic             q_ready;
  triad_pkg::work_t q_data;

  triad_front u_front (
    .clk, .rst,
    .in_valid, .in_ready, .in_data,
    .w_valid(f_valid), .w_ready(f_ready), .w_data(f_data)
  );

  triad_queue #(.DEPTH(triad_pkg::QDEPTH)) u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  triad_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst,
    .w_valid(q_valid), .w_ready(q_ready), .w_data(q_data),
    .out_valid, .out_ready, .out_data
  );

endmodule
